/* rtl/core/ray_box_list_nearest_hit_unit_defines.svh */
// Assertion macros for the box trace unit.
// The module that uses them provides clk and rst.
`ifndef RAY_BOX_LIST_NEAREST_HIT_UNIT_DEFINES_SVH
`define RAY_BOX_LIST_NEAREST_HIT_UNIT_DEFINES_SVH

`define RBNH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define RBNH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define RBNH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/rbnh_pkg.sv */
// ----------------------------------------------------------------------------
// rbnh_pkg
// Shared constants, state type and control structs of the box trace unit.
// ----------------------------------------------------------------------------
package rbnh_pkg;

  localparam int MAX_BOX_COUNT_DEF = 256;
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int IN_W     = 23;
  localparam int SLOT_W   = 8;
  localparam int CFG_W    = 9;
  localparam int S_DATA_W = 152;
  localparam int M_DATA_W = 104;
  localparam int FRAC_OUT_W = 17;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_TRACE = 1'b1;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BOX,
    ST_AXIS,
    ST_DIV_MIN,
    ST_DIV_MAX,
    ST_NEXT,
    ST_COMMIT,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic trace_start;
    logic box_rd;
    logic box_init;
    logic axis_eval;
    logic div_start;
    logic div_sel;
    logic cap_t1;
    logic slab_upd;
    logic axis_check;
    logic axis_inc;
    logic axis_clr;
    logic box_commit;
    logic end_mul;
    logic end_add;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic d_zero;
    logic div_done;
    logic slab_fail;
    logic axis_last;
    logic out_free;
  } status_t;

endpackage

/* rtl/core/rbnh_ram.sv */
// ----------------------------------------------------------------------------
// rbnh_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rbnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/rbnh_div.sv */
// ----------------------------------------------------------------------------
// rbnh_div
// Restoring serial divider, one quotient bit per cycle, signed result.
// ----------------------------------------------------------------------------
module rbnh_div #(
  parameter int QW    = 41,
  parameter int DEN_W = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [QW-1:0]        num_mag,
  input  logic [DEN_W-1:0]     den_mag,
  input  logic                 neg,
  output logic                 done,
  output logic signed [QW:0]   quot
);

  localparam int CNT_W = $clog2(QW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [QW-1:0]    quo;
  logic             negr;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;

  assign rem_sh  = {rem, quo[QW-1]};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num_mag;
      den  <= den_mag;
      negr <= neg;
    end else if (busy) begin
      if (!rem_sub[DEN_W]) begin
        rem <= rem_sub[DEN_W-1:0];
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DEN_W-1:0];
        quo <= {quo[QW-2:0], 1'b0};
      end
    end
  end

  assign quot = negr ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

/* rtl/core/rbnh_ctrl.sv */
// ----------------------------------------------------------------------------
// rbnh_ctrl
// Sequencer: box scan, per-axis slab steps, end point and result handoff.
// ----------------------------------------------------------------------------
module rbnh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              mode,
  output logic              s_tready,
  input  rbnh_pkg::status_t status,
  output rbnh_pkg::cmd_t    cmd
);

  rbnh_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbnh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rbnh_pkg::ST_IDLE: begin
        if (s_tvalid && mode == rbnh_pkg::MODE_TRACE) begin
          state_next = rbnh_pkg::ST_SCAN;
        end
      end
      rbnh_pkg::ST_SCAN: begin
        state_next = status.scan_done ? rbnh_pkg::ST_MUL : rbnh_pkg::ST_BOX;
      end
      rbnh_pkg::ST_BOX: state_next = rbnh_pkg::ST_AXIS;
      rbnh_pkg::ST_AXIS: begin
        state_next = status.d_zero ? rbnh_pkg::ST_NEXT : rbnh_pkg::ST_DIV_MIN;
      end
      rbnh_pkg::ST_DIV_MIN: begin
        if (status.div_done) begin
          state_next = rbnh_pkg::ST_DIV_MAX;
        end
      end
      rbnh_pkg::ST_DIV_MAX: begin
        if (status.div_done) begin
          state_next = rbnh_pkg::ST_NEXT;
        end
      end
      rbnh_pkg::ST_NEXT: begin
        if (status.slab_fail || status.axis_last) begin
          state_next = rbnh_pkg::ST_COMMIT;
        end else begin
          state_next = rbnh_pkg::ST_AXIS;
        end
      end
      rbnh_pkg::ST_COMMIT: state_next = rbnh_pkg::ST_SCAN;
      rbnh_pkg::ST_MUL: state_next = rbnh_pkg::ST_ADD;
      rbnh_pkg::ST_ADD: begin
        state_next = status.axis_last ? rbnh_pkg::ST_DONE : rbnh_pkg::ST_MUL;
      end
      rbnh_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_next = rbnh_pkg::ST_IDLE;
        end
      end
      default: state_next = rbnh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      rbnh_pkg::ST_IDLE: begin
        s_tready        = 1'b1;
        cmd.load_wr     = s_tvalid && mode == rbnh_pkg::MODE_LOAD;
        cmd.trace_start = s_tvalid && mode == rbnh_pkg::MODE_TRACE;
      end
      rbnh_pkg::ST_SCAN: begin
        cmd.box_rd   = !status.scan_done;
        cmd.axis_clr = status.scan_done;
      end
      rbnh_pkg::ST_BOX: cmd.box_init = 1'b1;
      rbnh_pkg::ST_AXIS: begin
        cmd.axis_eval = 1'b1;
        cmd.div_start = !status.d_zero;
        cmd.div_sel   = 1'b0;
      end
      rbnh_pkg::ST_DIV_MIN: begin
        cmd.cap_t1    = status.div_done;
        cmd.div_start = status.div_done;
        cmd.div_sel   = 1'b1;
      end
      rbnh_pkg::ST_DIV_MAX: cmd.slab_upd = status.div_done;
      rbnh_pkg::ST_NEXT: begin
        cmd.axis_check = 1'b1;
        cmd.axis_inc   = !(status.slab_fail || status.axis_last);
      end
      rbnh_pkg::ST_COMMIT: cmd.box_commit = 1'b1;
      rbnh_pkg::ST_MUL: cmd.end_mul = 1'b1;
      rbnh_pkg::ST_ADD: begin
        cmd.end_add  = 1'b1;
        cmd.axis_inc = !status.axis_last;
      end
      rbnh_pkg::ST_DONE: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/rbnh_dp.sv */
// ----------------------------------------------------------------------------
// rbnh_dp
// Datapath: box table, slab registers, shared divider, end point, output reg.
// ----------------------------------------------------------------------------
`include "ray_box_list_nearest_hit_unit_defines.svh"

module rbnh_dp #(
  parameter int MAX_BOX_COUNT = rbnh_pkg::MAX_BOX_COUNT_DEF,
  parameter int COORD_WIDTH   = rbnh_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = rbnh_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rbnh_pkg::cmd_t                    cmd,
  output rbnh_pkg::status_t                 status,
  input  logic [rbnh_pkg::S_DATA_W-1:0]     s_tdata,
  input  logic                              cfg_wr_en,
  input  logic [rbnh_pkg::CFG_W-1:0]        cfg_wr_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rbnh_pkg::M_DATA_W-1:0]     m_tdata
);

  localparam int IN_W   = rbnh_pkg::IN_W;
  localparam int CW     = COORD_WIDTH;
  localparam int AW     = (MAX_BOX_COUNT > 1) ? $clog2(MAX_BOX_COUNT) : 1;
  localparam int CNT_W  = $clog2(MAX_BOX_COUNT + 1);
  localparam int CMP_W  = (CNT_W > rbnh_pkg::CFG_W) ? CNT_W : rbnh_pkg::CFG_W;
  localparam int DIFF_W = ((CW > IN_W) ? CW : IN_W) + 1;
  localparam int QW     = DIFF_W + FRACTION_BITS;
  localparam int T_W    = QW + 1;
  localparam int DEN_W  = IN_W + 1;
  localparam int FRAC_W = FRACTION_BITS + 1;
  localparam int P_W    = DEN_W + FRAC_W + 1;
  localparam int ROW_W  = 6 * CW;
  localparam logic [FRAC_W-1:0]       ONE_F  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic signed [T_W-1:0]   ONE_T  = $signed(T_W'(ONE_F));
  localparam logic signed [P_W-1:0]   SAT_HI = (P_W'(1) <<< (IN_W - 1)) - P_W'(1);
  localparam logic signed [P_W-1:0]   SAT_LO = -(P_W'(1) <<< (IN_W - 1));

  logic [rbnh_pkg::SLOT_W-1:0] in_slot;
  logic signed [IN_W-1:0]      in_a [3];
  logic signed [IN_W-1:0]      in_b [3];

  logic                  ram_we;
  logic [ROW_W-1:0]      ram_wdata;
  logic [ROW_W-1:0]      ram_rdata;
  logic signed [CW-1:0]  mn_arr [3];
  logic signed [CW-1:0]  mx_arr [3];

  logic signed [IN_W-1:0]  s_reg [3];
  logic signed [DEN_W-1:0] d_reg [3];
  logic [CMP_W-1:0]        box_idx;
  logic [1:0]              axis;
  logic [rbnh_pkg::CFG_W-1:0] box_count;

  logic signed [T_W-1:0]    tmin, tmax, t1;
  logic [1:0]               amin;
  logic                     sneg, fail;
  logic signed [DIFF_W-1:0] ibest;
  logic [1:0]               iba;
  logic                     ibn;

  logic [FRAC_W-1:0]        best;
  logic                     hit, hneg;
  logic [7:0]               hbox;
  logic [1:0]               haxis;
  logic signed [P_W-1:0]    prod;
  logic signed [IN_W-1:0]   endp [3];

  logic signed [IN_W-1:0]   s_a;
  logic signed [DEN_W-1:0]  d_a;
  logic signed [CW-1:0]     mn_a, mx_a;
  logic signed [DIFF_W-1:0] diff_lo, diff_hi, dlo, pdiff;
  logic [DIFF_W-1:0]        pabs;
  logic [QW-1:0]            num_mag;
  logic [DEN_W-1:0]         den_mag;
  logic                     div_neg, div_done;
  logic signed [T_W-1:0]    quot;

  logic                     take1, take2, n1;
  logic signed [DIFF_W-1:0] b1;
  logic [1:0]               a1;
  logic                     swap;
  logic signed [T_W-1:0]    lo_t, hi_t, f_box;
  logic [CMP_W-1:0]         n_lim;
  logic signed [P_W-1:0]    end_sum;
  logic signed [IN_W-1:0]   end_sat;

  // unpack
  always_comb begin
    in_slot = s_tdata[rbnh_pkg::SLOT_W-1:0];
    for (int i = 0; i < 3; i++) begin
      in_a[i] = $signed(s_tdata[rbnh_pkg::SLOT_W + i*IN_W +: IN_W]);
      in_b[i] = $signed(s_tdata[rbnh_pkg::SLOT_W + (3+i)*IN_W +: IN_W]);
      ram_wdata[i*CW +: CW]     = CW'(in_a[i]);
      ram_wdata[(3+i)*CW +: CW] = CW'(in_b[i]);
      mn_arr[i] = $signed(ram_rdata[i*CW +: CW]);
      mx_arr[i] = $signed(ram_rdata[(3+i)*CW +: CW]);
    end
  end

  assign ram_we = cmd.load_wr && (int'(in_slot) < MAX_BOX_COUNT);

  rbnh_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_BOX_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_slot)),
    .wdata (ram_wdata),
    .re    (cmd.box_rd),
    .raddr (box_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // per-axis operands
  always_comb begin
    s_a     = s_reg[axis];
    d_a     = d_reg[axis];
    mn_a    = mn_arr[axis];
    mx_a    = mx_arr[axis];
    diff_lo = DIFF_W'(mn_a) - DIFF_W'(s_a);
    diff_hi = DIFF_W'(mx_a) - DIFF_W'(s_a);
    dlo     = DIFF_W'(s_a) - DIFF_W'(mn_a);
    pdiff   = cmd.div_sel ? diff_hi : diff_lo;
    pabs    = pdiff[DIFF_W-1] ? DIFF_W'(-pdiff) : DIFF_W'(pdiff);
    num_mag = {pabs, {FRACTION_BITS{1'b0}}};
    den_mag = d_a[DEN_W-1] ? DEN_W'(-d_a) : DEN_W'(d_a);
    div_neg = pdiff[DIFF_W-1] ^ d_a[DEN_W-1];
  end

  rbnh_div #(
    .QW    (QW),
    .DEN_W (DEN_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .num_mag (num_mag),
    .den_mag (den_mag),
    .neg     (div_neg),
    .done    (div_done),
    .quot    (quot)
  );

  // nearest face for a start inside the box
  always_comb begin
    take1 = (axis == rbnh_pkg::AXIS_X) || (dlo < ibest);
    b1    = take1 ? dlo : ibest;
    a1    = take1 ? axis : iba;
    n1    = take1 ? 1'b1 : ibn;
    take2 = diff_hi < b1;
  end

  always_comb begin
    swap    = t1 > quot;
    lo_t    = swap ? quot : t1;
    hi_t    = swap ? t1 : quot;
    f_box   = (amin == rbnh_pkg::AXIS_NONE) ? '0 : tmin;
    n_lim   = (CMP_W'(box_count) > CMP_W'(MAX_BOX_COUNT)) ? CMP_W'(MAX_BOX_COUNT)
                                                          : CMP_W'(box_count);
    end_sum = P_W'(s_a) + (prod >>> FRACTION_BITS);
    if (end_sum > SAT_HI) begin
      end_sat = SAT_HI[IN_W-1:0];
    end else if (end_sum < SAT_LO) begin
      end_sat = SAT_LO[IN_W-1:0];
    end else begin
      end_sat = end_sum[IN_W-1:0];
    end
  end

  always_comb begin
    status.scan_done = box_idx >= n_lim;
    status.d_zero    = d_a == '0;
    status.div_done  = div_done;
    status.slab_fail = fail || (tmin > tmax);
    status.axis_last = axis == rbnh_pkg::AXIS_Z;
    status.out_free  = !m_tvalid || m_tready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
      box_idx   <= '0;
      axis      <= '0;
      fail      <= 1'b0;
      hit       <= 1'b0;
      best      <= ONE_F;
      hbox      <= '0;
      haxis     <= rbnh_pkg::AXIS_NONE;
      hneg      <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        box_count <= cfg_wr_data;
      end
      if (cmd.trace_start) begin
        box_idx <= '0;
        hit     <= 1'b0;
        best    <= ONE_F;
        hbox    <= '0;
        haxis   <= rbnh_pkg::AXIS_NONE;
        hneg    <= 1'b0;
      end
      if (cmd.box_init || cmd.axis_clr) begin
        axis <= '0;
      end else if (cmd.axis_inc) begin
        axis <= axis + 2'd1;
      end
      if (cmd.box_init) begin
        fail <= 1'b0;
      end else if (cmd.axis_eval && status.d_zero) begin
        if ((!diff_lo[DIFF_W-1] && |diff_lo) || diff_hi[DIFF_W-1]) begin
          fail <= 1'b1;
        end
      end else if (cmd.axis_check) begin
        fail <= status.slab_fail;
      end
      if (cmd.box_commit) begin
        box_idx <= box_idx + CMP_W'(1);
        if (!fail && f_box < $signed(T_W'(best))) begin
          best  <= f_box[FRAC_W-1:0];
          hit   <= 1'b1;
          hbox  <= box_idx[7:0];
          haxis <= (amin == rbnh_pkg::AXIS_NONE) ? iba : amin;
          hneg  <= (amin == rbnh_pkg::AXIS_NONE) ? ibn : sneg;
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.trace_start) begin
      for (int i = 0; i < 3; i++) begin
        s_reg[i] <= in_a[i];
        d_reg[i] <= DEN_W'(in_b[i]) - DEN_W'(in_a[i]);
      end
    end
    if (cmd.box_init) begin
      tmin <= '0;
      tmax <= ONE_T;
      amin <= rbnh_pkg::AXIS_NONE;
      sneg <= 1'b0;
    end
    if (cmd.axis_eval) begin
      ibest <= take2 ? diff_hi : b1;
      iba   <= take2 ? axis : a1;
      ibn   <= take2 ? 1'b0 : n1;
    end
    if (cmd.cap_t1) begin
      t1 <= quot;
    end
    if (cmd.slab_upd) begin
      if (lo_t > tmin) begin
        tmin <= lo_t;
        amin <= axis;
        sneg <= !swap;
      end
      if (hi_t < tmax) begin
        tmax <= hi_t;
      end
    end
    if (cmd.end_mul) begin
      prod <= P_W'(d_a * $signed({1'b0, best}));
    end
    if (cmd.end_add) begin
      endp[axis] <= end_sat;
    end
    if (cmd.out_load) begin
      m_tdata <= {6'd0, endp[2], endp[1], endp[0], hneg, haxis, hbox,
                  rbnh_pkg::FRAC_OUT_W'(best), hit};
    end
  end

  `RBNH_ASSERT(a_best_range, best <= ONE_F, "best fraction above one")
  `RBNH_ASSERT_IMP(a_miss_clean, !hit, (best == ONE_F) && (hbox == '0) && (haxis == rbnh_pkg::AXIS_NONE), "miss fields not clean")
  `RBNH_ASSERT_IMP(a_slab_live, cmd.slab_upd, !fail && !tmin[T_W-1], "slab update on failed box")
  `RBNH_ASSERT_NXT(a_out_load, cmd.out_load, m_tvalid, "result not presented")

endmodule

/* rtl/core/ray_box_list_nearest_hit_unit.sv */
// ----------------------------------------------------------------------------
// ray_box_list_nearest_hit_unit
// Segment trace against a table of axis-aligned boxes, reporting the nearest hit.
// ----------------------------------------------------------------------------
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   load box or trace segment (mode in s_tuser)
// m_*      out  m_tvalid/m_tready   one trace result
// cfg_*    in   cfg_wr_en           box_count
//
// Load: the box is written to its table slot when accepted. Trace: boxes are scanned
// in turn through the serial divider, quotient width Q (41 at defaults).
// Reset: synchronous, clears control state; table contents stay undefined.
// One request in flight; a held result does not block loads.
module ray_box_list_nearest_hit_unit #(
  parameter int MAX_BOX_COUNT = rbnh_pkg::MAX_BOX_COUNT_DEF,
  parameter int COORD_WIDTH   = rbnh_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = rbnh_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // box_slot, a_x, a_y, a_z, b_x, b_y, b_z
  input  logic [rbnh_pkg::S_DATA_W-1:0]  s_tdata,
  // mode
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // hit, fraction, hit_box, normal_axis, normal_negative, end_x, end_y, end_z
  output logic [rbnh_pkg::M_DATA_W-1:0]  m_tdata,
  input  logic                           cfg_wr_en,
  input  logic [rbnh_pkg::CFG_W-1:0]     cfg_wr_data
);

  rbnh_pkg::cmd_t    cmd;
  rbnh_pkg::status_t status;

  rbnh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .mode     (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rbnh_dp #(
    .MAX_BOX_COUNT (MAX_BOX_COUNT),
    .COORD_WIDTH   (COORD_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .s_tdata     (s_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule
